// File: rtl/ebd_pkg.sv
// shared types and constants of the exponent bit decomposer
`default_nettype none

package ebd_pkg;

   localparam int ColW   = 6;
   localparam int CountW = 32;
   localparam int IndexW = 31;
   localparam int ExpW   = 64;
   localparam int WidthW = 7;
   localparam int Columns = 64;
   localparam int CsrDataW = 32;

   typedef enum logic [1:0] {
      OP_LOAD    = 2'd0,
      OP_SCATTER = 2'd1,
      OP_READ    = 2'd2,
      OP_NONE    = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      CSR_ELEMENT_BYTES = 2'd0,
      CSR_SIGNED_MODE   = 2'd1,
      CSR_EMIT_ENTRIES  = 2'd2,
      CSR_UNUSED        = 2'd3
   } csr_index_type;

   typedef enum logic {
      KIND_ENTRY   = 1'b0,
      KIND_READOUT = 1'b1
   } reply_kind_type;

   typedef struct packed {
      logic            bit_set;
      logic [ColW-1:0] col;
      logic            last;
      logic            done;
      logic            sign;
   } walk_bit_type;

endpackage

`default_nettype wire

// File: rtl/ebd_counter_ram.sv
// bit column counter memory with per-entry valid bits
`default_nettype none

module ebd_counter_ram
   import ebd_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              wr_en,
   input  wire logic [ColW-1:0]   wr_addr,
   input  wire logic [CountW-1:0] wr_data,
   input  wire logic              rd_en,
   input  wire logic [ColW-1:0]   rd_addr,
   output logic      [CountW-1:0] rd_data
);

   logic [CountW-1:0]  mem_ff [Columns];
   logic [Columns-1:0] vld_ff;
   logic [CountW-1:0]  rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (wr_en) begin
         vld_ff[wr_addr] <= 1'b1;
      end
   end

   // entries never written read as zero
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= vld_ff[rd_addr] ? mem_ff[rd_addr] : '0;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: rtl/ebd_bit_walker.sv
// bit-serial exponent walker with serial two's complement negation
`default_nettype none

module ebd_bit_walker
   import ebd_pkg::*;
#(
   parameter int MAX_ELEMENT_BITS = 64
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic              step,
   input  wire logic [ExpW-1:0]   exponent,
   input  wire logic [WidthW-1:0] width,
   input  wire logic              signed_mode,
   output walk_bit_type           walk
);

   logic [MAX_ELEMENT_BITS-1:0] sr_ff, sr_in;
   logic [MAX_ELEMENT_BITS-1:0] mk_ff, mk_in;
   logic [MAX_ELEMENT_BITS-1:0] start_mask;
   logic [MAX_ELEMENT_BITS-1:0] upper;
   logic [MAX_ELEMENT_BITS-1:0] mk_upper;
   logic [ColW-1:0]             col_ff, col_in;
   logic                        seen_ff, seen_in;
   logic                        neg_ff, neg_in;
   logic [ColW-1:0]             sign_pos;
   logic                        raw_sign;
   logic                        seen_next;
   logic                        invert;
   logic                        invert_next;
   logic                        rest;

   always_comb begin
      for (int i = 0; i < MAX_ELEMENT_BITS; i++) begin
         start_mask[i] = (WidthW'(i) < width);
      end
   end

   assign sign_pos = ColW'(width - WidthW'(1));
   assign raw_sign = (width != '0) && exponent[sign_pos];

   // below the first one bit the magnitude copies, above it inverts
   assign invert      = neg_ff && seen_ff;
   assign seen_next   = seen_ff | sr_ff[0];
   assign invert_next = neg_ff && seen_next;
   assign upper       = sr_ff >> 1;
   assign mk_upper    = mk_ff >> 1;
   assign rest        = invert_next ? |(~upper & mk_upper) : |(upper & mk_upper);

   always_comb begin
      walk.bit_set = mk_ff[0] & (sr_ff[0] ^ invert);
      walk.col     = col_ff;
      walk.last    = !rest;
      walk.done    = !rest;
      walk.sign    = neg_ff;
   end

   always_comb begin
      sr_in   = sr_ff;
      mk_in   = mk_ff;
      col_in  = col_ff;
      seen_in = seen_ff;
      neg_in  = neg_ff;
      if (start) begin
         sr_in   = exponent[MAX_ELEMENT_BITS-1:0];
         mk_in   = start_mask;
         col_in  = '0;
         seen_in = 1'b0;
         neg_in  = signed_mode & raw_sign;
      end else if (step) begin
         sr_in   = upper;
         mk_in   = mk_upper;
         col_in  = col_ff + ColW'(1);
         seen_in = seen_next;
      end
   end

   always_ff @(posedge clock) begin
      sr_ff <= sr_in;
      col_ff <= col_in;
      neg_ff <= neg_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mk_ff <= '0;
         seen_ff <= 1'b0;
      end else begin
         mk_ff <= mk_in;
         seen_ff <= seen_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/exponent_bit_decomposer_unit.sv
// top level of the exponent bit decomposer: sequencer, counter update stage, result register
//
// channel  direction  transaction
// req_     in         op, bit_position, load_value, exponent, element_index
// rsp_     out        reply_kind, bit_position_res, slot, entry, count_value, last
// csr_     in         csr_index, csr_wdata (register write)
//
// op 0 (load) writes a counter, op 3 does nothing, op 2 (read) returns one as a readout
// op 1 walks the bit columns up to the highest set magnitude bit
// the exponent is walked one bit per cycle unless stalled; each set bit's counter is read,
// written back incremented, and with emit entries on the entry goes to the result register
// reset restores the default configuration and zeroes all 64 counters at once
// a result register held by rsp_ready low stalls the walk in place
`default_nettype none

module exponent_bit_decomposer_unit
   import ebd_pkg::*;
#(
   parameter int MAX_ELEMENT_BITS = 64
) (
   input  wire logic                clock,
   input  wire logic                reset,

   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire logic [1:0]          req_op,
   input  wire logic [ColW-1:0]     req_bit_position,
   input  wire logic [CountW-1:0]   req_load_value,
   input  wire logic [ExpW-1:0]     req_exponent,
   input  wire logic [IndexW-1:0]   req_element_index,

   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic                     rsp_reply_kind,
   output logic      [ColW-1:0]     rsp_bit_position_res,
   output logic      [CountW-1:0]   rsp_slot,
   output logic      [CountW-1:0]   rsp_entry,
   output logic      [CountW-1:0]   rsp_count_value,
   output logic                     rsp_last,

   input  wire logic                csr_valid,
   output logic                     csr_ready,
   input  wire logic [1:0]          csr_index,
   input  wire logic [CsrDataW-1:0] csr_wdata
);

   localparam logic [WidthW-1:0] MaxWidth = WidthW'(MAX_ELEMENT_BITS);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_WALK = 2'b10
   } state_type;

   state_type         state_ff, state_in;
   logic [3:0]        bytes_ff;
   logic              signed_ff;
   logic              emit_ff;
   logic [IndexW-1:0] idx_ff, idx_in;
   logic              sign_ff, sign_in;

   logic              p1_valid_ff, p1_valid_in;
   logic              p1_readout_ff, p1_readout_in;
   logic [ColW-1:0]   p1_col_ff, p1_col_in;
   logic              p1_last_ff, p1_last_in;

   logic              rsp_valid_ff, rsp_valid_in;
   reply_kind_type    rsp_kind_ff, rsp_kind_in;
   logic [ColW-1:0]   rsp_col_ff, rsp_col_in;
   logic [CountW-1:0] rsp_slot_ff, rsp_slot_in;
   logic [CountW-1:0] rsp_entry_ff, rsp_entry_in;
   logic [CountW-1:0] rsp_count_ff, rsp_count_in;
   logic              rsp_last_ff, rsp_last_in;

   logic [3:0]        bytes_cap;
   logic [WidthW-1:0] width_raw;
   logic [WidthW-1:0] width;
   logic              req_acc;
   logic              op_load;
   logic              op_scatter;
   logic              op_read;
   logic              walking;
   logic              s1_stall;
   logic              advance;
   logic              retire;
   logic              rsp_load;
   walk_bit_type      walk;

   logic              ram_wr_en;
   logic [ColW-1:0]   ram_wr_addr;
   logic [CountW-1:0] ram_wr_data;
   logic              ram_rd_en;
   logic [ColW-1:0]   ram_rd_addr;
   logic [CountW-1:0] ram_rd_data;

   // configuration
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_ff <= 4'd4;
         signed_ff <= 1'b0;
         emit_ff <= 1'b1;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_ELEMENT_BYTES: bytes_ff <= csr_wdata[3:0];
            CSR_SIGNED_MODE:   signed_ff <= csr_wdata[0];
            CSR_EMIT_ENTRIES:  emit_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   assign bytes_cap = (bytes_ff > 4'd8) ? 4'd8 : bytes_ff;
   assign width_raw = {bytes_cap, 3'b000};
   assign width     = (width_raw > MaxWidth) ? MaxWidth : width_raw;

   // request side
   assign walking    = (state_ff == ST_WALK);
   assign req_ready  = (state_ff == ST_IDLE) && !p1_valid_ff;
   assign req_acc    = req_valid && req_ready;
   assign op_load    = req_acc && (op_type'(req_op) == OP_LOAD);
   assign op_scatter = req_acc && (op_type'(req_op) == OP_SCATTER);
   assign op_read    = req_acc && (op_type'(req_op) == OP_READ);

   assign s1_stall = p1_valid_ff && (p1_readout_ff || emit_ff) && rsp_valid_ff && !rsp_ready;
   assign advance  = !s1_stall;
   assign retire   = p1_valid_ff && advance;
   assign rsp_load = retire && (p1_readout_ff || emit_ff);

   ebd_bit_walker #(
      .MAX_ELEMENT_BITS(MAX_ELEMENT_BITS)
   ) u_walker (
      .clock       (clock),
      .reset       (reset),
      .start       (op_scatter),
      .step        (walking && advance),
      .exponent    (req_exponent),
      .width       (width),
      .signed_mode (signed_ff),
      .walk        (walk)
   );

   // counter memory ports
   always_comb begin
      ram_wr_en   = 1'b0;
      ram_wr_addr = p1_col_ff;
      ram_wr_data = ram_rd_data + CountW'(1);
      if (op_load) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = req_bit_position;
         ram_wr_data = req_load_value;
      end else if (retire && !p1_readout_ff) begin
         ram_wr_en = 1'b1;
      end
   end

   assign ram_rd_en   = op_read || (walking && advance && walk.bit_set);
   assign ram_rd_addr = op_read ? req_bit_position : walk.col;

   ebd_counter_ram u_counters (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // sequencer and update stage
   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      sign_in       = sign_ff;
      p1_valid_in   = p1_valid_ff;
      p1_readout_in = p1_readout_ff;
      p1_col_in     = p1_col_ff;
      p1_last_in    = p1_last_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (op_scatter) begin
               state_in = ST_WALK;
               idx_in   = req_element_index;
            end
         end
         ST_WALK: begin
            sign_in = walk.sign;
            if (advance && walk.done) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (advance) begin
         p1_valid_in   = op_read || (walking && walk.bit_set);
         p1_readout_in = op_read;
         p1_col_in     = op_read ? req_bit_position : walk.col;
         p1_last_in    = op_read || walk.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         p1_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         p1_valid_ff <= p1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      sign_ff <= sign_in;
      p1_readout_ff <= p1_readout_in;
      p1_col_ff <= p1_col_in;
      p1_last_ff <= p1_last_in;
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_kind_in  = rsp_kind_ff;
      rsp_col_in   = rsp_col_ff;
      rsp_slot_in  = rsp_slot_ff;
      rsp_entry_in = rsp_entry_ff;
      rsp_count_in = rsp_count_ff;
      rsp_last_in  = rsp_last_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_col_in   = p1_col_ff;
         rsp_last_in  = p1_last_ff;
         if (p1_readout_ff) begin
            rsp_kind_in  = KIND_READOUT;
            rsp_slot_in  = '0;
            rsp_entry_in = '0;
            rsp_count_in = ram_rd_data;
         end else begin
            rsp_kind_in  = KIND_ENTRY;
            rsp_slot_in  = ram_rd_data;
            rsp_entry_in = {sign_ff, idx_ff};
            rsp_count_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_kind_ff <= rsp_kind_in;
      rsp_col_ff <= rsp_col_in;
      rsp_slot_ff <= rsp_slot_in;
      rsp_entry_ff <= rsp_entry_in;
      rsp_count_ff <= rsp_count_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_reply_kind       = rsp_kind_ff;
   assign rsp_bit_position_res = rsp_col_ff;
   assign rsp_slot             = rsp_slot_ff;
   assign rsp_entry            = rsp_entry_ff;
   assign rsp_count_value      = rsp_count_ff;
   assign rsp_last             = rsp_last_ff;

   // checks
   a_no_rw_collision: assert property (@(posedge clock) disable iff (reset)
      ram_wr_en && ram_rd_en |-> ram_wr_addr != ram_rd_addr)
      else $error("counter read and write hit the same column");

   a_stall_holds_stage: assert property (@(posedge clock) disable iff (reset)
      s1_stall |=> p1_valid_ff && $stable(p1_col_ff) && $stable(p1_last_ff))
      else $error("update stage changed while stalled");

   a_readout_only_idle: assert property (@(posedge clock) disable iff (reset)
      p1_valid_ff && p1_readout_ff |-> state_ff == ST_IDLE)
      else $error("counter readout overlaps an exponent walk");

   a_walk_blocks_requests: assert property (@(posedge clock) disable iff (reset)
      walking |-> !req_ready && !op_load)
      else $error("request taken during an exponent walk");

endmodule

`default_nettype wire
